// ===== design/smte_pkg.sv =====
package smte_pkg;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  localparam logic [6:0] MaxWriteNibbles = 7'd80;
  localparam logic [6:0] MaxReadBytes    = 7'd15;

  typedef enum logic [2:0] {
    ACT_START_READ  = 3'd0,
    ACT_START_WRITE = 3'd1,
    ACT_START_RESET = 3'd2,
    ACT_NIBBLE      = 3'd3,
    ACT_RX_BYTE     = 3'd4,
    ACT_TIMEOUT     = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    KIND_TX   = 3'd0,
    KIND_DATA = 3'd1,
    KIND_NEED = 3'd2,
    KIND_DONE = 3'd3,
    KIND_FAIL = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    FC_NONE       = 3'd0,
    FC_ADDR_ECHO  = 3'd1,
    FC_COUNT_ECHO = 3'd2,
    FC_CHECKSUM   = 3'd3,
    FC_WRITE_ECHO = 3'd4,
    FC_TIMEOUT    = 3'd5,
    FC_BAD_REQ    = 3'd6
  } fail_e;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_SET   = 2'd1,
    MODE_UNSET = 2'd2,
    MODE_BAD   = 2'd3
  } mode_e;

  localparam logic [7:0] ResetCmd     = 8'h06;
  localparam logic [7:0] ResetAck     = 8'h02;
  localparam logic [7:0] AddrCmdBase  = 8'h82;
  localparam logic [7:0] CountCmdBase = 8'hC2;
  localparam logic [7:0] CountCmdMax  = 8'hFE;
  localparam logic [7:0] CountAckBase = 8'h30;

  function automatic logic [7:0] mode_base(input logic [1:0] md);
    case (md)
      MODE_WRITE: mode_base = 8'h42;
      MODE_SET:   mode_base = 8'h12;
      MODE_UNSET: mode_base = 8'h32;
      default:    mode_base = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] mode_ack(input logic [1:0] md);
    case (md)
      MODE_WRITE: mode_ack = 8'h10;
      MODE_SET:   mode_ack = 8'h04;
      MODE_UNSET: mode_ack = 8'h0C;
      default:    mode_ack = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] addr_byte(input logic [3:0] nib);
    addr_byte = AddrCmdBase + {2'b00, nib, 2'b00};
  endfunction

  function automatic logic [7:0] count_byte(input logic [6:0] n);
    logic [9:0] c;
    c = {2'b00, CountCmdBase} + {1'b0, n, 2'b00};
    count_byte = (c > {2'b00, CountCmdMax}) ? CountCmdMax : c[7:0];
  endfunction

endpackage

// ===== design/serial_memory_transaction_engine.sv =====
// Host-side engine for a byte-echo serial memory link. Each input item is a command
// (start read/write/reset, next write nibble), a byte received from the station, or a
// receive timeout; each produces zero or one result item: a byte to transmit, a read data
// byte, a request for the next write nibble, done (with count, zero for reset), or failed
// (with code). Each echo but the reset ack is checked on arrival; a mismatch or timeout
// returns the engine to idle with a fail item; a bad request gets a fail item, phase kept.
// An item is taken every cycle while the output register is empty or being drained, and
// its result shows the cycle after: one state and one output register, one pass of logic.
module serial_memory_transaction_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // address[15:0], count[22:16], mode[24:23], nibble[28:25], rx_byte[36:29], zero pad
  input  logic [smte_pkg::InDataW-1:0]    s_axis_tdata,
  // action[2:0]
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // value[7:0], fail_code[10:8], zero pad
  output logic [smte_pkg::OutDataW-1:0]   m_axis_tdata,
  // kind[2:0]
  output logic [2:0]                      m_axis_tuser
);
  import smte_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RESET  = 3'd1,
    PH_RADDR  = 3'd2,
    PH_RCOUNT = 3'd3,
    PH_RDATA  = 3'd4,
    PH_WADDR  = 3'd5,
    PH_WNIB   = 3'd6,
    PH_WECHO  = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [15:0] held_addr_q, held_addr_d;
  logic [6:0]  req_cnt_q, req_cnt_d;
  logic [6:0]  progress_q, progress_d;
  logic [7:0]  sum_q, sum_d;
  logic [1:0]  wmode_q, wmode_d;
  logic [3:0]  pend_nib_q, pend_nib_d;

  logic        m_valid_q;
  logic [2:0]  m_kind_q;
  logic [7:0]  m_value_q;
  logic [2:0]  m_code_q;

  logic        res_vld;
  logic [2:0]  res_kind;
  logic [7:0]  res_value;
  logic [2:0]  res_code;

  logic        in_acc;
  logic [2:0]  act;
  logic [15:0] in_addr;
  logic [6:0]  in_cnt;
  logic [1:0]  in_mode;
  logic [3:0]  in_nib;
  logic [7:0]  in_rx;
  logic [3:0]  cur_nib;
  logic [3:0]  next_nib;
  logic [1:0]  idx_inc;
  logic [6:0]  prog_inc;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign act     = s_axis_tuser;
  assign in_addr = s_axis_tdata[15:0];
  assign in_cnt  = s_axis_tdata[22:16];
  assign in_mode = s_axis_tdata[24:23];
  assign in_nib  = s_axis_tdata[28:25];
  assign in_rx   = s_axis_tdata[36:29];

  assign idx_inc  = idx_q + 2'd1;
  assign prog_inc = progress_q + 7'd1;
  assign cur_nib  = held_addr_q[{~idx_q, 2'b00} +: 4];
  assign next_nib = held_addr_q[{~idx_inc, 2'b00} +: 4];

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    held_addr_d = held_addr_q;
    req_cnt_d   = req_cnt_q;
    progress_d  = progress_q;
    sum_d       = sum_q;
    wmode_d     = wmode_q;
    pend_nib_d  = pend_nib_q;
    res_vld     = 1'b0;
    res_kind    = KIND_TX;
    res_value   = 8'h00;
    res_code    = FC_NONE;

    case (act)
      ACT_START_READ, ACT_START_WRITE, ACT_START_RESET: begin
        res_vld = 1'b1;
        if (phase_q != PH_IDLE) begin
          res_kind = KIND_FAIL;
          res_code = FC_BAD_REQ;
        end else if (act == ACT_START_RESET) begin
          phase_d   = PH_RESET;
          res_value = ResetCmd;
        end else if ((act == ACT_START_READ && in_cnt > MaxReadBytes) ||
                     (act == ACT_START_WRITE &&
                      (in_mode == MODE_BAD || in_cnt > MaxWriteNibbles))) begin
          res_kind = KIND_FAIL;
          res_code = FC_BAD_REQ;
        end else begin
          held_addr_d = in_addr;
          req_cnt_d   = in_cnt;
          idx_d       = 2'd0;
          progress_d  = 7'd0;
          sum_d       = 8'h00;
          wmode_d     = in_mode;
          phase_d     = (act == ACT_START_READ) ? PH_RADDR : PH_WADDR;
          res_value   = addr_byte(in_addr[15:12]);
        end
      end
      ACT_NIBBLE: begin
        if (phase_q == PH_WNIB && wmode_q != MODE_BAD) begin
          pend_nib_d = in_nib;
          phase_d    = PH_WECHO;
          res_vld    = 1'b1;
          res_value  = mode_base(wmode_q) + {2'b00, in_nib, 2'b00};
        end
      end
      ACT_RX_BYTE: begin
        case (phase_q)
          PH_RESET: begin
            if (in_rx == ResetAck) begin
              phase_d  = PH_IDLE;
              res_vld  = 1'b1;
              res_kind = KIND_DONE;
            end
          end
          PH_RADDR, PH_WADDR: begin
            res_vld = 1'b1;
            if (in_rx != {2'b00, idx_q, cur_nib}) begin
              phase_d  = PH_IDLE;
              res_kind = KIND_FAIL;
              res_code = FC_ADDR_ECHO;
            end else if (idx_q != 2'd3) begin
              idx_d     = idx_inc;
              res_value = addr_byte(next_nib);
            end else if (phase_q == PH_RADDR) begin
              phase_d   = PH_RCOUNT;
              res_value = count_byte(req_cnt_q);
            end else if (req_cnt_q == 7'd0) begin
              phase_d  = PH_IDLE;
              res_kind = KIND_DONE;
            end else begin
              phase_d  = PH_WNIB;
              res_kind = KIND_NEED;
            end
          end
          PH_RCOUNT: begin
            if (in_rx != CountAckBase + {1'b0, req_cnt_q}) begin
              phase_d  = PH_IDLE;
              res_vld  = 1'b1;
              res_kind = KIND_FAIL;
              res_code = FC_COUNT_ECHO;
            end else begin
              phase_d = PH_RDATA;
            end
          end
          PH_RDATA: begin
            res_vld = 1'b1;
            if (progress_q < req_cnt_q) begin
              progress_d = prog_inc;
              sum_d      = sum_q + in_rx;
              res_kind   = KIND_DATA;
              res_value  = in_rx;
            end else if (in_rx != sum_q) begin
              phase_d  = PH_IDLE;
              res_kind = KIND_FAIL;
              res_code = FC_CHECKSUM;
            end else begin
              phase_d   = PH_IDLE;
              res_kind  = KIND_DONE;
              res_value = {1'b0, req_cnt_q};
            end
          end
          PH_WECHO: begin
            res_vld = 1'b1;
            if (wmode_q == MODE_BAD ||
                in_rx != {4'h0, pend_nib_q} + mode_ack(wmode_q)) begin
              phase_d  = PH_IDLE;
              res_kind = KIND_FAIL;
              res_code = FC_WRITE_ECHO;
            end else begin
              progress_d = prog_inc;
              if (prog_inc >= req_cnt_q) begin
                phase_d   = PH_IDLE;
                res_kind  = KIND_DONE;
                res_value = {1'b0, req_cnt_q};
              end else begin
                phase_d  = PH_WNIB;
                res_kind = KIND_NEED;
              end
            end
          end
          default: ;
        endcase
      end
      ACT_TIMEOUT: begin
        if (phase_q != PH_IDLE) begin
          phase_d  = PH_IDLE;
          res_vld  = 1'b1;
          res_kind = KIND_FAIL;
          res_code = FC_TIMEOUT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      idx_q       <= 2'd0;
      held_addr_q <= 16'h0000;
      req_cnt_q   <= 7'd0;
      progress_q  <= 7'd0;
      sum_q       <= 8'h00;
      wmode_q     <= MODE_WRITE;
      pend_nib_q  <= 4'h0;
      m_valid_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q     <= phase_d;
        idx_q       <= idx_d;
        held_addr_q <= held_addr_d;
        req_cnt_q   <= req_cnt_d;
        progress_q  <= progress_d;
        sum_q       <= sum_d;
        wmode_q     <= wmode_d;
        pend_nib_q  <= pend_nib_d;
        m_valid_q   <= res_vld;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_vld) begin
      m_kind_q  <= res_kind;
      m_value_q <= res_value;
      m_code_q  <= res_code;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b00000, m_code_q, m_value_q};
  assign m_axis_tuser  = m_kind_q;

  a_fail_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_kind_q == KIND_FAIL |-> m_code_q != FC_NONE && m_value_q == 8'h00)
    else $error("fail item without code or with nonzero value");

  a_ok_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_kind_q != KIND_FAIL |-> m_code_q == FC_NONE)
    else $error("non-fail item carries a fail code");

  a_idle_rx_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q == PH_IDLE && act == ACT_RX_BYTE |-> !res_vld)
    else $error("byte received while idle produced an item");

  a_read_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RDATA |-> progress_q <= req_cnt_q && req_cnt_q <= MaxReadBytes)
    else $error("read progress beyond requested count");

  a_fail_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_vld && res_kind == KIND_FAIL && res_code != FC_BAD_REQ
    |=> phase_q == PH_IDLE)
    else $error("engine not idle after failure");

endmodule
